### hw/rtl/stack_word_executor_defines.svh
// Assertion macros shared by the stack word executor RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef STACK_WORD_EXECUTOR_DEFINES_SVH
`define STACK_WORD_EXECUTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWE_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/swe_pkg.sv
// Shared types and constants for the stack word executor.
// No dependencies; the RTL modules import this package and the interfaces name it by scope.
package swe_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int WORD_W          = 32;
  localparam int MODE_W          = 5;

  localparam logic [WORD_W-1:0] FLAG_TRUE    = '1;
  localparam logic [WORD_W-1:0] FLAG_FALSE   = '0;
  localparam logic [WORD_W-1:0] CHAR_NEWLINE = WORD_W'(10);

  typedef enum logic [MODE_W-1:0] {
    W_LIT     = 5'd0,
    W_ADD     = 5'd1,
    W_SUB     = 5'd2,
    W_MUL     = 5'd3,
    W_DIV     = 5'd4,
    W_MOD     = 5'd5,
    W_REM     = 5'd6,
    W_EQ      = 5'd7,
    W_LT      = 5'd8,
    W_GT      = 5'd9,
    W_AND     = 5'd10,
    W_OR      = 5'd11,
    W_NOT     = 5'd12,
    W_DUP     = 5'd13,
    W_DROP    = 5'd14,
    W_SWAP    = 5'd15,
    W_OVER    = 5'd16,
    W_ROT     = 5'd17,
    W_DOT     = 5'd18,
    W_EMIT    = 5'd19,
    W_CR      = 5'd20,
    W_EMPTYQ  = 5'd21,
    W_RESET   = 5'd22,
    W_IF      = 5'd23,
    W_ELSE    = 5'd24,
    W_THEN    = 5'd25,
    W_DEFINE  = 5'd26,
    W_UNKNOWN = 5'd27
  } word_mode_t;

  typedef enum logic [3:0] {
    S_OK         = 4'd0,
    S_OVERFLOW   = 4'd1,
    S_UNDERFLOW  = 4'd2,
    S_DIV_ZERO   = 4'd3,
    S_IF_EMPTY   = 4'd4,
    S_STRAY_ELSE = 4'd5,
    S_STRAY_THEN = 4'd6,
    S_NO_DEFINE  = 4'd7,
    S_UNKNOWN    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    K_NONE   = 2'd0,
    K_NUMBER = 2'd1,
    K_CHAR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    C_NONE = 2'd0,
    C_SKIP = 2'd1,
    C_RUN  = 2'd2
  } cond_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD3,
    ST_ROT2,
    ST_LAST,
    ST_DIV
  } exec_state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] modulo;
  } div_rsp_t;

endpackage

### hw/rtl/swe_channels.sv
// Handshake channel interfaces for the stack word executor.
// Depends on swe_pkg for field widths.
interface swe_in_if;
  logic                              valid;
  logic                              ready;
  logic [swe_pkg::MODE_W-1:0]        mode;
  logic signed [swe_pkg::WORD_W-1:0] literal;

  modport source (output valid, mode, literal, input ready);
  modport sink (input valid, mode, literal, output ready);
endinterface

interface swe_out_if #(
  parameter int STACK_DEPTH = swe_pkg::STACK_DEPTH_DEF
);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  logic                              valid;
  logic                              ready;
  logic [3:0]                        status;
  logic                              skipped;
  logic [1:0]                        out_kind;
  logic signed [swe_pkg::WORD_W-1:0] out_print;
  logic [DEPTH_W-1:0]                depth_now;
  logic signed [swe_pkg::WORD_W-1:0] top_value;
  logic [1:0]                        branch_state;

  modport source (output valid, status, skipped, out_kind, out_print, depth_now,
                  top_value, branch_state, input ready);
  modport sink (input valid, status, skipped, out_kind, out_print, depth_now,
                top_value, branch_state, output ready);
endinterface

### hw/rtl/swe_stack_ram.sv
// Stack storage: one write port, one read port, registered read data.
// Depends on swe_pkg for the word width.
module swe_stack_ram #(
  parameter int DEPTH = swe_pkg::STACK_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [swe_pkg::WORD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [swe_pkg::WORD_W-1:0] rd_data
);
  import swe_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/swe_alu.sv
// Combinational arithmetic, compare and logic unit for two-operand words and the one-operand not.
// Depends on swe_pkg for word codes and flag constants.
module swe_alu (
  input  logic [swe_pkg::MODE_W-1:0] mode,
  input  logic [swe_pkg::WORD_W-1:0] a,
  input  logic [swe_pkg::WORD_W-1:0] b,
  output logic [swe_pkg::WORD_W-1:0] result
);
  import swe_pkg::*;

  logic [WORD_W-1:0] prod;

  // Only the low word of the product is kept, which is the wrapping result.
  assign prod = a * b;

  always_comb begin
    case (mode)
      W_ADD:    result = a + b;
      W_SUB:    result = a - b;
      W_MUL:    result = prod;
      W_EQ:     result = (a == b) ? FLAG_TRUE : FLAG_FALSE;
      W_LT:     result = ($signed(a) < $signed(b)) ? FLAG_TRUE : FLAG_FALSE;
      W_GT:     result = ($signed(b) < $signed(a)) ? FLAG_TRUE : FLAG_FALSE;
      W_AND:    result = ((a != '0) && (b != '0)) ? FLAG_TRUE : FLAG_FALSE;
      W_OR:     result = ((a != '0) || (b != '0)) ? FLAG_TRUE : FLAG_FALSE;
      W_NOT:    result = (b == '0) ? FLAG_TRUE : FLAG_FALSE;
      default:  result = FLAG_FALSE;
    endcase
  end

endmodule

### hw/rtl/swe_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, with sign fixup
// for truncating quotient, truncating remainder and floored modulo.
// Depends on swe_pkg for the request and response structs.
module swe_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  swe_pkg::div_req_t req,
  output swe_pkg::div_rsp_t rsp
);
  import swe_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W-1:0] dvs_raw_r, dvs_raw_nxt;
  logic              neg_q_r, neg_q_nxt;
  logic              neg_r_r, neg_r_nxt;

  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] quot_s;
  logic [WORD_W-1:0] rem_s;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    dvs_raw_nxt = dvs_raw_r;
    neg_q_nxt   = neg_q_r;
    neg_r_nxt   = neg_r_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      quo_nxt     = req.dividend[WORD_W-1] ? (WORD_W'(0) - req.dividend) : req.dividend;
      rem_nxt     = '0;
      dvs_nxt     = req.divisor[WORD_W-1] ? (WORD_W'(0) - req.divisor) : req.divisor;
      dvs_raw_nxt = req.divisor;
      neg_q_nxt   = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
      neg_r_nxt   = req.dividend[WORD_W-1];
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_nxt = diff[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    dvs_raw_r <= dvs_raw_nxt;
    neg_q_r   <= neg_q_nxt;
    neg_r_r   <= neg_r_nxt;
  end

  assign quot_s = neg_q_r ? (WORD_W'(0) - quo_r) : quo_r;
  assign rem_s  = neg_r_r ? (WORD_W'(0) - rem_r) : rem_r;

  // Floored modulo takes the divisor's sign when the remainder is nonzero.
  always_comb begin
    rsp.busy = busy_r;
    rsp.quot = quot_s;
    rsp.rem  = rem_s;
    if ((rem_s != '0) && (rem_s[WORD_W-1] != dvs_raw_r[WORD_W-1])) begin
      rsp.modulo = rem_s + dvs_raw_r;
    end else begin
      rsp.modulo = rem_s;
    end
  end

endmodule

### hw/rtl/stack_word_executor.sv
// Top level of the stack word executor: sequencer, top-of-stack register,
// stack RAM, ALU and divider. Depends on swe_pkg, swe_channels and the defines header.
//
//   Channel   Direction  Handshake        Contents
//   in_ch     input      valid / ready    mode, literal
//   out_ch    output     valid / ready    status, skipped, out_kind, out_print,
//                                         depth_now, top_value, branch_state
//
// Most words pass IDLE (accept) and EXEC (one read-modify-write of the stack RAM).
// Swap adds LAST, divide by zero RD3, rot RD3, ROT2 and LAST; these are RAM port turns.
// Div, mod and rem wait in DIV while the one-bit-per-cycle divider is busy.
// Reset clears depth, conditional state and the result valid flag; no RAM clearing.
// A word's final cycle waits while the result register is full and not being taken.
`include "stack_word_executor_defines.svh"

module stack_word_executor #(
  parameter int STACK_DEPTH = swe_pkg::STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  swe_in_if.sink    in_ch,
  swe_out_if.source out_ch
);
  import swe_pkg::*;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  exec_state_t       state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [WORD_W-1:0] lit_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [WORD_W-1:0] tos_r, tos_nxt;
  logic [WORD_W-1:0] aux_r, aux_nxt;
  cond_t             cond_r, cond_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_skipped_r;
  kind_t              out_kind_r;
  logic [WORD_W-1:0]  out_print_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic [WORD_W-1:0]  out_top_r;
  cond_t              out_branch_r;

  status_t           res_status;
  logic              res_skipped;
  kind_t             res_kind;
  logic [WORD_W-1:0] res_value;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [WORD_W-1:0] mem_wd;
  logic [WORD_W-1:0] nos;
  logic              push_en;
  logic [WORD_W-1:0] push_data;

  logic [WORD_W-1:0] alu_res;
  logic [WORD_W-1:0] div_res;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [DEPTH_W-1:0] dm1, dm2, dm3;
  logic has1, has2, has3, full;
  logic in_accept, is_skip, is_bin, is_divop, div_zero;
  logic exec_to_div, exec_to_rd3, exec_to_last, exec_fin;
  logic fin, out_free, go;
  logic res_depth_ok;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign dm1  = depth_r - DEPTH_W'(1);
  assign dm2  = depth_r - DEPTH_W'(2);
  assign dm3  = depth_r - DEPTH_W'(3);
  assign has1 = (depth_r != '0);
  assign has2 = (depth_r >= DEPTH_W'(2));
  assign has3 = (depth_r >= DEPTH_W'(3));
  assign full = (depth_r >= DEPTH_W'(STACK_DEPTH));

  assign is_skip  = (cond_r == C_SKIP);
  assign is_bin   = (mode_r >= W_ADD) && (mode_r <= W_OR);
  assign is_divop = (mode_r == W_DIV) || (mode_r == W_MOD) || (mode_r == W_REM);
  assign div_zero = is_bin && has2 && is_divop && (tos_r == '0);

  assign exec_to_div  = !is_skip && is_bin && has2 && is_divop && (tos_r != '0);
  assign exec_to_rd3  = !is_skip && (div_zero || ((mode_r == W_ROT) && has3));
  assign exec_to_last = !is_skip && (mode_r == W_SWAP) && has2;
  assign exec_fin     = !(exec_to_div || exec_to_rd3 || exec_to_last);

  assign fin = ((state_r == ST_EXEC) && exec_fin) ||
               ((state_r == ST_RD3) && (mode_r != W_ROT)) ||
               (state_r == ST_LAST) ||
               ((state_r == ST_DIV) && !div_rsp.busy);
  assign out_free = !out_valid_r || out_ch.ready;
  assign go       = !fin || out_free;

  swe_stack_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we && go),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re && go),
    .rd_addr (mem_ra),
    .rd_data (nos)
  );

  swe_alu u_alu (
    .mode   (mode_r),
    .a      (nos),
    .b      (tos_r),
    .result (alu_res)
  );

  swe_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_res = (mode_r == W_DIV) ? div_rsp.quot :
                   (mode_r == W_MOD) ? div_rsp.modulo : div_rsp.rem;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_to_div) state_nxt = ST_DIV;
        else if (exec_to_rd3) state_nxt = ST_RD3;
        else if (exec_to_last) state_nxt = ST_LAST;
        else if (go) state_nxt = ST_IDLE;
      end
      ST_RD3: begin
        if (mode_r == W_ROT) state_nxt = ST_ROT2;
        else if (go) state_nxt = ST_IDLE;
      end
      ST_ROT2: state_nxt = ST_LAST;
      ST_LAST: begin
        if (go) state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (!div_rsp.busy && go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and RAM port control per state.
  always_comb begin
    mem_we           = 1'b0;
    mem_wa           = '0;
    mem_wd           = '0;
    mem_re           = 1'b0;
    mem_ra           = dm2[ADDR_W-1:0];
    depth_nxt        = depth_r;
    tos_nxt          = tos_r;
    aux_nxt          = aux_r;
    cond_nxt         = cond_r;
    res_status       = S_OK;
    res_skipped      = 1'b0;
    res_kind         = K_NONE;
    res_value        = '0;
    push_en          = 1'b0;
    push_data        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = nos;
    div_req.divisor  = tos_r;
    case (state_r)
      ST_IDLE: begin
        mem_re = in_accept;
        mem_ra = dm2[ADDR_W-1:0];
      end
      ST_EXEC: begin
        if (is_skip) begin
          if (mode_r == W_ELSE) cond_nxt = C_RUN;
          else if (mode_r == W_THEN) cond_nxt = C_NONE;
          else res_skipped = 1'b1;
        end else if (is_bin) begin
          if (!has2) begin
            res_status = S_UNDERFLOW;
          end else if (is_divop) begin
            if (tos_r == '0) begin
              mem_re = 1'b1;
              mem_ra = dm3[ADDR_W-1:0];
            end else begin
              div_req.start = 1'b1;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wa    = dm2[ADDR_W-1:0];
            mem_wd    = alu_res;
            tos_nxt   = alu_res;
            depth_nxt = dm1;
          end
        end else begin
          case (mode_r)
            W_LIT: begin
              push_en   = 1'b1;
              push_data = lit_r;
            end
            W_NOT: begin
              if (!has1) begin
                res_status = S_UNDERFLOW;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = dm1[ADDR_W-1:0];
                mem_wd  = alu_res;
                tos_nxt = alu_res;
              end
            end
            W_DUP: begin
              if (!has1) res_status = S_UNDERFLOW;
              else begin
                push_en   = 1'b1;
                push_data = tos_r;
              end
            end
            W_DROP: begin
              if (!has1) res_status = S_UNDERFLOW;
              else begin
                depth_nxt = dm1;
                tos_nxt   = nos;
              end
            end
            W_SWAP: begin
              if (!has2) res_status = S_UNDERFLOW;
              else begin
                mem_we  = 1'b1;
                mem_wa  = dm2[ADDR_W-1:0];
                mem_wd  = tos_r;
                aux_nxt = nos;
              end
            end
            W_OVER: begin
              if (!has2) res_status = S_UNDERFLOW;
              else begin
                push_en   = 1'b1;
                push_data = nos;
              end
            end
            W_ROT: begin
              if (!has3) res_status = S_UNDERFLOW;
              else begin
                aux_nxt = nos;
                mem_re  = 1'b1;
                mem_ra  = dm3[ADDR_W-1:0];
              end
            end
            W_DOT: begin
              if (!has1) res_status = S_UNDERFLOW;
              else begin
                res_kind  = K_NUMBER;
                res_value = tos_r;
                depth_nxt = dm1;
                tos_nxt   = nos;
              end
            end
            W_EMIT: begin
              if (!has1) res_status = S_UNDERFLOW;
              else begin
                res_kind  = K_CHAR;
                res_value = {{(WORD_W - 8){1'b0}}, tos_r[7:0]};
                depth_nxt = dm1;
                tos_nxt   = nos;
              end
            end
            W_CR: begin
              res_kind  = K_CHAR;
              res_value = CHAR_NEWLINE;
            end
            W_EMPTYQ: begin
              push_en   = 1'b1;
              push_data = has1 ? FLAG_FALSE : FLAG_TRUE;
            end
            W_RESET: depth_nxt = '0;
            W_IF: begin
              if (!has1) res_status = S_IF_EMPTY;
              else begin
                depth_nxt = dm1;
                tos_nxt   = nos;
                cond_nxt  = (tos_r == '0) ? C_SKIP : C_RUN;
              end
            end
            W_ELSE: begin
              if (cond_r == C_RUN) cond_nxt = C_SKIP;
              else res_status = S_STRAY_ELSE;
            end
            W_THEN: begin
              if (cond_r == C_NONE) res_status = S_STRAY_THEN;
              else cond_nxt = C_NONE;
            end
            W_DEFINE: res_status = S_NO_DEFINE;
            default:  res_status = S_UNKNOWN;
          endcase
          if (push_en) begin
            if (full) begin
              res_status = S_OVERFLOW;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = depth_r[ADDR_W-1:0];
              mem_wd    = push_data;
              tos_nxt   = push_data;
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
        end
      end
      ST_RD3: begin
        // The RAM now returns the third entry from the top.
        if (mode_r == W_ROT) begin
          mem_we  = 1'b1;
          mem_wa  = dm3[ADDR_W-1:0];
          mem_wd  = aux_r;
          aux_nxt = nos;
        end else begin
          res_status = S_DIV_ZERO;
          depth_nxt  = dm2;
          tos_nxt    = nos;
        end
      end
      ST_ROT2: begin
        mem_we = 1'b1;
        mem_wa = dm2[ADDR_W-1:0];
        mem_wd = tos_r;
      end
      ST_LAST: begin
        mem_we  = 1'b1;
        mem_wa  = dm1[ADDR_W-1:0];
        mem_wd  = aux_r;
        tos_nxt = aux_r;
      end
      ST_DIV: begin
        if (!div_rsp.busy) begin
          mem_we    = 1'b1;
          mem_wa    = dm2[ADDR_W-1:0];
          mem_wd    = div_res;
          tos_nxt   = div_res;
          depth_nxt = dm1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      cond_r      <= C_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        depth_r <= depth_nxt;
        cond_r  <= cond_nxt;
      end
      if (fin && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_ch.mode;
      lit_r  <= in_ch.literal;
    end
    if (go) begin
      tos_r <= tos_nxt;
      aux_r <= aux_nxt;
    end
    if (fin && go) begin
      out_status_r  <= res_status;
      out_skipped_r <= res_skipped;
      out_kind_r    <= res_kind;
      out_print_r   <= res_value;
      out_depth_r   <= depth_nxt;
      out_top_r     <= (depth_nxt == '0) ? '0 : tos_nxt;
      out_branch_r  <= cond_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.skipped      = out_skipped_r;
  assign out_ch.out_kind     = out_kind_r;
  assign out_ch.out_print    = out_print_r;
  assign out_ch.depth_now    = out_depth_r;
  assign out_ch.top_value    = out_top_r;
  assign out_ch.branch_state = out_branch_r;

  assign res_depth_ok = out_valid_r && (out_depth_r == depth_r);

  `SWE_ASSERT_HOLDS(a_depth_bound, 1'b1, depth_r <= DEPTH_W'(STACK_DEPTH), "depth above limit")
  `SWE_ASSERT_NEXT(a_result_depth, fin && go, res_depth_ok, "result depth mismatch")
  `SWE_ASSERT_HOLDS(a_div_quiet, state_r != ST_DIV, !div_rsp.busy, "divider busy while idle")
  `SWE_ASSERT_HOLDS(a_skip_ok, out_valid_r && out_skipped_r, out_status_r == S_OK, "skip flagged")

endmodule
